FILE: hdl/lspf_pkg.sv
// ----------------------------------------------------------------------------
// lspf_pkg
// Shared widths, status codes and beat types for the plane fit block.
// ----------------------------------------------------------------------------
package lspf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_POINTS = 1024;
  localparam int CNT_W      = 11;
  localparam int MINP_W     = 11;
  localparam int SUM1_W     = 27;
  localparam int SUM2_W     = 42;
  localparam int ENT_W      = 43;
  localparam int DET_W      = 96;
  localparam int QUO_W      = DET_W + FRAC_BITS;
  localparam int OUT_W      = 48;

  localparam logic [MINP_W-1:0] MINP_RESET = MINP_W'(6);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW      = 2'd1;
  localparam logic [1:0] ST_SINGULAR = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
    logic signed [SUM1_W-1:0] sx;
    logic signed [SUM1_W-1:0] sy;
    logic signed [SUM1_W-1:0] sz;
    logic signed [SUM2_W-1:0] sxx;
    logic signed [SUM2_W-1:0] sxy;
    logic signed [SUM2_W-1:0] syy;
    logic signed [SUM2_W-1:0] sxz;
    logic signed [SUM2_W-1:0] syz;
  } snap_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] beta_const;
    logic signed [OUT_W-1:0] beta_x;
    logic signed [OUT_W-1:0] beta_y;
    logic [1:0]              status;
    logic [CNT_W-1:0]        points;
  } result_t;

endpackage

FILE: hdl/lspf_fifo.sv
// ----------------------------------------------------------------------------
// lspf_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module lspf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? nxt(wr_q) : wr_q;
    rd_d  = do_pop ? nxt(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/lspf_front.sv
// ----------------------------------------------------------------------------
// lspf_front
// Accumulates count and running sums, classifies each set on its last point.
// ----------------------------------------------------------------------------
module lspf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pt_valid_i,
  input  logic [lspf_pkg::SAMPLE_W-1:0] x_i,
  input  logic [lspf_pkg::SAMPLE_W-1:0] y_i,
  input  logic [lspf_pkg::SAMPLE_W-1:0] z_i,
  input  logic                         last_i,
  input  logic                         cfg_valid_i,
  input  logic [lspf_pkg::MINP_W-1:0]  cfg_data_i,
  input  logic                         snap_full_i,
  output logic                         snap_push_o,
  output lspf_pkg::snap_t              snap_o
);
  import lspf_pkg::*;

  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [MINP_W-1:0]        min_q;
  logic                     ovf_q, ovf_d;
  logic signed [SUM1_W-1:0] sx_q, sx_d, sy_q, sy_d, sz_q, sz_d;
  logic signed [SUM2_W-1:0] sxx_q, sxx_d, sxy_q, sxy_d, syy_q, syy_d;
  logic signed [SUM2_W-1:0] sxz_q, sxz_d, syz_q, syz_d;
  logic signed [SAMPLE_W-1:0]   xs, ys, zs;
  logic signed [2*SAMPLE_W-1:0] pxx, pxy, pyy, pxz, pyz;
  logic                     accept;

  assign accept = pt_valid_i & ~snap_full_i;
  assign xs  = signed'(x_i);
  assign ys  = signed'(y_i);
  assign zs  = signed'(z_i);
  assign pxx = xs * xs;
  assign pxy = xs * ys;
  assign pyy = ys * ys;
  assign pxz = xs * zs;
  assign pyz = ys * zs;

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    sz_d  = sz_q;
    sxx_d = sxx_q;
    sxy_d = sxy_q;
    syy_d = syy_q;
    sxz_d = sxz_q;
    syz_d = syz_q;
    if (accept) begin
      if (cnt_q == CNT_W'(MAX_POINTS)) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
        sx_d  = sx_q + SUM1_W'(xs);
        sy_d  = sy_q + SUM1_W'(ys);
        sz_d  = sz_q + SUM1_W'(zs);
        sxx_d = sxx_q + SUM2_W'(pxx);
        sxy_d = sxy_q + SUM2_W'(pxy);
        syy_d = syy_q + SUM2_W'(pyy);
        sxz_d = sxz_q + SUM2_W'(pxz);
        syz_d = syz_q + SUM2_W'(pyz);
      end
    end

    snap_o.count = cnt_d;
    snap_o.sx    = sx_d;
    snap_o.sy    = sy_d;
    snap_o.sz    = sz_d;
    snap_o.sxx   = sxx_d;
    snap_o.sxy   = sxy_d;
    snap_o.syy   = syy_d;
    snap_o.sxz   = sxz_d;
    snap_o.syz   = syz_d;
    if (ovf_d) begin
      snap_o.status = ST_OVERFLOW;
    end else if (cnt_d < min_q) begin
      snap_o.status = ST_FEW;
    end else begin
      snap_o.status = ST_OK;
    end

    snap_push_o = accept & last_i;
    if (snap_push_o) begin
      cnt_d = '0;
      ovf_d = 1'b0;
      sx_d  = '0;
      sy_d  = '0;
      sz_d  = '0;
      sxx_d = '0;
      sxy_d = '0;
      syy_d = '0;
      sxz_d = '0;
      syz_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
      min_q <= MINP_RESET;
      sx_q  <= '0;
      sy_q  <= '0;
      sz_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      syy_q <= '0;
      sxz_q <= '0;
      syz_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      sz_q  <= sz_d;
      sxx_q <= sxx_d;
      sxy_q <= sxy_d;
      syy_q <= syy_d;
      sxz_q <= sxz_d;
      syz_q <= syz_d;
      if (cfg_valid_i) begin
        min_q <= cfg_data_i;
      end
    end
  end

endmodule

FILE: hdl/lspf_solver.sv
// ----------------------------------------------------------------------------
// lspf_solver
// Cramer's rule solve: shift-add multiplier for the determinants and a
// restoring divider for the scaled quotients.
// ----------------------------------------------------------------------------
module lspf_solver (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              snap_empty_i,
  input  lspf_pkg::snap_t   snap_i,
  output logic              snap_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output lspf_pkg::result_t res_o
);
  import lspf_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LOAD    = 3'd1;
  localparam logic [2:0] S_MUL     = 3'd2;
  localparam logic [2:0] S_ACC     = 3'd3;
  localparam logic [2:0] S_DETDONE = 3'd4;
  localparam logic [2:0] S_DIV     = 3'd5;
  localparam logic [2:0] S_QDONE   = 3'd6;
  localparam logic [2:0] S_EMIT    = 3'd7;

  localparam int MCW = $clog2(ENT_W + 1);
  localparam int DCW = $clog2(QUO_W + 1);

  localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic [2:0]              state_q, state_d;
  logic [1:0]              k_q, k_d, j_q, j_d, ph_q, ph_d;
  logic [MCW-1:0]          mcnt_q, mcnt_d;
  logic [DCW-1:0]          dcnt_q, dcnt_d;
  logic [1:0]              status_q, status_d;

  snap_t                   snap_q, snap_d;
  logic signed [DET_W-1:0] t_q, t_d, acc_q, acc_d, den_q, den_d;
  logic [DET_W-1:0]        ma_q, ma_d, mp_q, mp_d;
  logic [ENT_W-1:0]        mb_q, mb_d;
  logic                    mneg_q, mneg_d, dneg_q, dneg_d;
  logic [QUO_W-1:0]        dn_q, dn_d;
  logic [DET_W-1:0]        drem_q, drem_d, dden_q, dden_d;
  logic signed [OUT_W-1:0] bc_q, bc_d, bx_q, bx_d, by_q, by_d;

  logic signed [ENT_W-1:0] mat [3][3];
  logic signed [ENT_W-1:0] rhs [3];
  logic [1:0]              c1, c2;
  logic signed [DET_W-1:0] opa, prod;
  logic signed [ENT_W-1:0] opb;
  logic [DET_W-1:0]        opa_mag, num_mag;
  logic [ENT_W-1:0]        opb_mag;
  logic [DET_W:0]          r2, r2_sub;
  logic                    ge, sat;
  logic [OUT_W-1:0]        qmag;
  logic signed [OUT_W-1:0] qval;

  // matrix for determinant k: column k-1 replaced by the right-hand side
  always_comb begin
    mat[0][0] = ENT_W'(snap_q.count);
    mat[0][1] = ENT_W'(snap_q.sx);
    mat[0][2] = ENT_W'(snap_q.sy);
    mat[1][0] = ENT_W'(snap_q.sx);
    mat[1][1] = ENT_W'(snap_q.sxx);
    mat[1][2] = ENT_W'(snap_q.sxy);
    mat[2][0] = ENT_W'(snap_q.sy);
    mat[2][1] = ENT_W'(snap_q.sxy);
    mat[2][2] = ENT_W'(snap_q.syy);
    rhs[0]    = ENT_W'(snap_q.sz);
    rhs[1]    = ENT_W'(snap_q.sxz);
    rhs[2]    = ENT_W'(snap_q.syz);
    for (int c = 0; c < 3; c++) begin
      if (k_q == 2'(c + 1)) begin
        for (int r = 0; r < 3; r++) begin
          mat[r][c] = rhs[r];
        end
      end
    end
  end

  // cofactor expansion along row 0: phase 0/1 build the 2x2 minor, phase 2 scales it
  always_comb begin
    c1 = (j_q == 2'd0) ? 2'd1 : 2'd0;
    c2 = (j_q == 2'd2) ? 2'd1 : 2'd2;
    case (ph_q)
      2'd0: begin
        opa = DET_W'(mat[1][c1]);
        opb = mat[2][c2];
      end
      2'd1: begin
        opa = DET_W'(mat[1][c2]);
        opb = mat[2][c1];
      end
      default: begin
        opa = t_q;
        opb = mat[0][j_q];
      end
    endcase
    opa_mag = opa[DET_W-1] ? DET_W'(-opa) : DET_W'(opa);
    opb_mag = opb[ENT_W-1] ? ENT_W'(-opb) : ENT_W'(opb);
    prod    = mneg_q ? -signed'(mp_q) : signed'(mp_q);
    num_mag = acc_q[DET_W-1] ? DET_W'(-acc_q) : DET_W'(acc_q);

    r2     = {drem_q, dn_q[QUO_W-1]};
    r2_sub = r2 - {1'b0, dden_q};
    ge     = (r2 >= {1'b0, dden_q});

    sat  = |dn_q[QUO_W-1:OUT_W-1];
    qmag = {1'b0, dn_q[OUT_W-2:0]};
    if (sat) begin
      qval = dneg_q ? SAT_MIN : SAT_MAX;
    end else begin
      qval = dneg_q ? -signed'(qmag) : signed'(qmag);
    end
  end

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    j_d        = j_q;
    ph_d       = ph_q;
    mcnt_d     = mcnt_q;
    dcnt_d     = dcnt_q;
    status_d   = status_q;
    snap_d     = snap_q;
    t_d        = t_q;
    acc_d      = acc_q;
    den_d      = den_q;
    ma_d       = ma_q;
    mb_d       = mb_q;
    mp_d       = mp_q;
    mneg_d     = mneg_q;
    dneg_d     = dneg_q;
    dn_d       = dn_q;
    drem_d     = drem_q;
    dden_d     = dden_q;
    bc_d       = bc_q;
    bx_d       = bx_q;
    by_d       = by_q;
    snap_pop_o = 1'b0;
    res_push_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (!snap_empty_i && !res_full_i) begin
          snap_pop_o = 1'b1;
          snap_d     = snap_i;
          status_d   = snap_i.status;
          bc_d       = '0;
          bx_d       = '0;
          by_d       = '0;
          k_d        = 2'd0;
          j_d        = 2'd0;
          ph_d       = 2'd0;
          acc_d      = '0;
          state_d    = (snap_i.status == ST_OK) ? S_LOAD : S_EMIT;
        end
      end
      S_LOAD: begin
        ma_d    = opa_mag;
        mb_d    = opb_mag;
        mneg_d  = opa[DET_W-1] ^ opb[ENT_W-1];
        mp_d    = '0;
        mcnt_d  = MCW'(ENT_W);
        state_d = S_MUL;
      end
      S_MUL: begin
        if (mb_q[0]) begin
          mp_d = mp_q + ma_q;
        end
        ma_d   = ma_q << 1;
        mb_d   = mb_q >> 1;
        mcnt_d = mcnt_q - 1'b1;
        if (mcnt_q == MCW'(1)) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        case (ph_q)
          2'd0:    t_d = prod;
          2'd1:    t_d = t_q - prod;
          default: acc_d = (j_q == 2'd1) ? acc_q - prod : acc_q + prod;
        endcase
        if (ph_q == 2'd2) begin
          ph_d = 2'd0;
          if (j_q == 2'd2) begin
            j_d     = 2'd0;
            state_d = S_DETDONE;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_LOAD;
          end
        end else begin
          ph_d    = ph_q + 1'b1;
          state_d = S_LOAD;
        end
      end
      S_DETDONE: begin
        acc_d = '0;
        if (k_q == 2'd0) begin
          if (acc_q == '0) begin
            status_d = ST_SINGULAR;
            state_d  = S_EMIT;
          end else begin
            den_d   = acc_q;
            k_d     = 2'd1;
            state_d = S_LOAD;
          end
        end else begin
          dneg_d  = acc_q[DET_W-1] ^ den_q[DET_W-1];
          dn_d    = {num_mag, {FRAC_BITS{1'b0}}};
          drem_d  = '0;
          dden_d  = den_q[DET_W-1] ? DET_W'(-den_q) : DET_W'(den_q);
          dcnt_d  = DCW'(QUO_W);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        drem_d = ge ? r2_sub[DET_W-1:0] : r2[DET_W-1:0];
        dn_d   = {dn_q[QUO_W-2:0], ge};
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == DCW'(1)) begin
          state_d = S_QDONE;
        end
      end
      S_QDONE: begin
        case (k_q)
          2'd1:    bc_d = qval;
          2'd2:    bx_d = qval;
          default: by_d = qval;
        endcase
        if (k_q == 2'd3) begin
          state_d = S_EMIT;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_LOAD;
        end
      end
      S_EMIT: begin
        res_push_o = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.beta_const = bc_q;
  assign res_o.beta_x     = bx_q;
  assign res_o.beta_y     = by_q;
  assign res_o.status     = status_q;
  assign res_o.points     = snap_q.count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= '0;
      j_q      <= '0;
      ph_q     <= '0;
      mcnt_q   <= '0;
      dcnt_q   <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      j_q      <= j_d;
      ph_q     <= ph_d;
      mcnt_q   <= mcnt_d;
      dcnt_q   <= dcnt_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
    t_q    <= t_d;
    acc_q  <= acc_d;
    den_q  <= den_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    mp_q   <= mp_d;
    mneg_q <= mneg_d;
    dneg_q <= dneg_d;
    dn_q   <= dn_d;
    drem_q <= drem_d;
    dden_q <= dden_d;
    bc_q   <= bc_d;
    bx_q   <= bx_d;
    by_q   <= by_d;
  end

endmodule

FILE: hdl/least_squares_plane_fit.sv
// Points are taken one per cycle while full is low; a point updates the sums in
// the cycle it is accepted. A last point queues a set for the solver; a set reporting
// too few points or overflow skips the solve, while a full solve computes four 3x3
// determinants on a shift-add multiplier and three divides. Points keep flowing while
// the solver works, until SNAP_DEPTH finished sets wait for it.
// Reset clears the sums, count, overflow flag and queues and sets min_points to 6.
// ----------------------------------------------------------------------------
// least_squares_plane_fit
// Least-squares plane fit z = b0 + b1*x + b2*y over runs of points.
// ----------------------------------------------------------------------------
module least_squares_plane_fit #(
  parameter int SNAP_DEPTH = 2,
  parameter int RES_DEPTH  = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [lspf_pkg::SAMPLE_W-1:0] coord_x_i,
  input  logic signed [lspf_pkg::SAMPLE_W-1:0] coord_y_i,
  input  logic signed [lspf_pkg::SAMPLE_W-1:0] measured_i,
  input  logic                                last_point_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [lspf_pkg::OUT_W-1:0]    beta_const_o,
  output logic signed [lspf_pkg::OUT_W-1:0]    beta_x_o,
  output logic signed [lspf_pkg::OUT_W-1:0]    beta_y_o,
  output logic [1:0]                          fit_status_o,
  output logic [lspf_pkg::CNT_W-1:0]          points_used_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lspf_pkg::MINP_W-1:0]         cfg_data_i
);
  import lspf_pkg::*;

  snap_t   snap_in, snap_out;
  result_t res_in, res_out;
  logic    snap_push, snap_full, snap_pop, snap_empty;
  logic    res_push, res_full;

  assign cfg_ready_o = 1'b1;

  lspf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pt_valid_i  (push),
    .x_i         (coord_x_i),
    .y_i         (coord_y_i),
    .z_i         (measured_i),
    .last_i      (last_point_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .snap_full_i (snap_full),
    .snap_push_o (snap_push),
    .snap_o      (snap_in)
  );

  assign full = snap_full;

  lspf_fifo #(
    .WIDTH ($bits(snap_t)),
    .DEPTH (SNAP_DEPTH)
  ) u_snap_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .data_i  (snap_in),
    .full_o  (snap_full),
    .pop_i   (snap_pop),
    .data_o  (snap_out),
    .empty_o (snap_empty)
  );

  lspf_solver u_solver (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_empty_i (snap_empty),
    .snap_i       (snap_out),
    .snap_pop_o   (snap_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  lspf_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign beta_const_o  = res_out.beta_const;
  assign beta_x_o      = res_out.beta_x;
  assign beta_y_o      = res_out.beta_y;
  assign fit_status_o  = res_out.status;
  assign points_used_o = res_out.points;

endmodule

FILE: tb/least_squares_plane_fit_checker.sv
// ----------------------------------------------------------------------------
// least_squares_plane_fit_checker
// Watches the point, result and min_points channels, predicts every fit from
// the accepted points and compares each popped result field by field.
// ----------------------------------------------------------------------------
module least_squares_plane_fit_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  input  logic                                 full_i,
  input  logic signed [lspf_pkg::SAMPLE_W-1:0] coord_x_i,
  input  logic signed [lspf_pkg::SAMPLE_W-1:0] coord_y_i,
  input  logic signed [lspf_pkg::SAMPLE_W-1:0] measured_i,
  input  logic                                 last_point_i,
  input  logic                                 empty_i,
  input  logic                                 pop_i,
  input  logic signed [lspf_pkg::OUT_W-1:0]    beta_const_i,
  input  logic signed [lspf_pkg::OUT_W-1:0]    beta_x_i,
  input  logic signed [lspf_pkg::OUT_W-1:0]    beta_y_i,
  input  logic [1:0]                           fit_status_i,
  input  logic [lspf_pkg::CNT_W-1:0]           points_used_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [lspf_pkg::MINP_W-1:0]          cfg_data_i,
  output int                                   error_count_o,
  output int                                   fits_pending_o
);
  import lspf_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam wide_t BETA_MAX = (wide_t'(1) <<< 47) - 1;
  localparam wide_t BETA_MIN = -(wide_t'(1) <<< 47);

  result_t             fit_queue[$];
  logic [MINP_W-1:0]   min_pts;
  int                  n_pts;
  longint              s_x, s_y, s_z, s_xx, s_xy, s_yy, s_xz, s_yz;
  logic                ovf_seen;

  function automatic wide_t det3(input wide_t m [0:8]);
    wide_t c0, c1, c2;
    c0 = m[4] * m[8] - m[5] * m[7];
    c1 = m[3] * m[8] - m[5] * m[6];
    c2 = m[3] * m[7] - m[4] * m[6];
    return m[0] * c0 - m[1] * c1 + m[2] * c2;
  endfunction

  // scaled by 2^FRAC_BITS, truncated toward zero, clamped to 48 bits
  function automatic logic signed [OUT_W-1:0] scaled_quot(input wide_t num, input wide_t den);
    wide_t q;
    q = (num <<< FRAC_BITS) / den;
    if (q > BETA_MAX) q = BETA_MAX;
    if (q < BETA_MIN) q = BETA_MIN;
    return q[OUT_W-1:0];
  endfunction

  function automatic result_t solve_fit();
    result_t r;
    wide_t   m [0:8];
    wide_t   mc [0:8];
    wide_t   rhs [0:2];
    wide_t   d;
    r = '0;
    r.points = n_pts[CNT_W-1:0];
    if (ovf_seen) begin
      r.status = ST_OVERFLOW;
    end else if (n_pts < int'(min_pts)) begin
      r.status = ST_FEW;
    end else begin
      m = '{wide_t'(n_pts), wide_t'(s_x), wide_t'(s_y),
            wide_t'(s_x), wide_t'(s_xx), wide_t'(s_xy),
            wide_t'(s_y), wide_t'(s_xy), wide_t'(s_yy)};
      rhs = '{wide_t'(s_z), wide_t'(s_xz), wide_t'(s_yz)};
      d = det3(m);
      if (d == 0) begin
        r.status = ST_SINGULAR;
      end else begin
        r.status = ST_OK;
        mc = m; mc[0] = rhs[0]; mc[3] = rhs[1]; mc[6] = rhs[2];
        r.beta_const = scaled_quot(det3(mc), d);
        mc = m; mc[1] = rhs[0]; mc[4] = rhs[1]; mc[7] = rhs[2];
        r.beta_x = scaled_quot(det3(mc), d);
        mc = m; mc[2] = rhs[0]; mc[5] = rhs[1]; mc[8] = rhs[2];
        r.beta_y = scaled_quot(det3(mc), d);
      end
    end
    return r;
  endfunction

  task automatic clear_sums();
    n_pts = 0;
    s_x = 0; s_y = 0; s_z = 0;
    s_xx = 0; s_xy = 0; s_yy = 0; s_xz = 0; s_yz = 0;
    ovf_seen = 1'b0;
  endtask

  assign fits_pending_o = fit_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    longint  x, y, z;
    result_t got, want;
    if (!rst_ni) begin
      min_pts = MINP_RESET;
      clear_sums();
      fit_queue.delete();
      error_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) min_pts = cfg_data_i;
      if (push_i && !full_i) begin
        x = coord_x_i; y = coord_y_i; z = measured_i;
        if (n_pts >= MAX_POINTS) begin
          ovf_seen = 1'b1;
        end else begin
          n_pts++;
          s_x += x; s_y += y; s_z += z;
          s_xx += x * x; s_xy += x * y; s_yy += y * y;
          s_xz += x * z; s_yz += y * z;
        end
        if (last_point_i) begin
          fit_queue = {fit_queue, solve_fit()};
          clear_sums();
        end
      end
      if (pop_i && !empty_i) begin
        got = '{beta_const_i, beta_x_i, beta_y_i, fit_status_i, points_used_i};
        if (fit_queue.size() == 0) begin
          error_count_o++;
          if (error_count_o <= 10) $display("unexpected fit result beat: %p", got);
        end else begin
          want = fit_queue.pop_front();
          if (got != want) begin
            error_count_o++;
            if (error_count_o <= 10)
              $display("fit mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

endmodule

FILE: tb/least_squares_plane_fit_test.sv
// ----------------------------------------------------------------------------
// least_squares_plane_fit_test
// Feeds point sets of assorted shapes and min_points settings into the plane
// fit block, with random gaps and result stalls; the checker does the scoring.
// ----------------------------------------------------------------------------
module least_squares_plane_fit_test;
  import lspf_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       push = 1'b0;
  logic                       full;
  logic signed [SAMPLE_W-1:0] coord_x = '0;
  logic signed [SAMPLE_W-1:0] coord_y = '0;
  logic signed [SAMPLE_W-1:0] measured = '0;
  logic                       last_point = 1'b0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [OUT_W-1:0]    beta_const, beta_x, beta_y;
  logic [1:0]                 fit_status;
  logic [CNT_W-1:0]           points_used;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [MINP_W-1:0]          cfg_data = '0;
  int                         error_count;
  int                         fits_pending;
  int                         cycles = 0;
  int                         pop_hold = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  least_squares_plane_fit i_dut (
    .clk_i, .rst_ni, .push, .full,
    .coord_x_i(coord_x), .coord_y_i(coord_y), .measured_i(measured),
    .last_point_i(last_point), .empty, .pop,
    .beta_const_o(beta_const), .beta_x_o(beta_x), .beta_y_o(beta_y),
    .fit_status_o(fit_status), .points_used_o(points_used),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  least_squares_plane_fit_checker i_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full),
    .coord_x_i(coord_x), .coord_y_i(coord_y), .measured_i(measured),
    .last_point_i(last_point), .empty_i(empty), .pop_i(pop),
    .beta_const_i(beta_const), .beta_x_i(beta_x), .beta_y_i(beta_y),
    .fit_status_i(fit_status), .points_used_i(points_used),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .error_count_o(error_count), .fits_pending_o(fits_pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("least_squares_plane_fit_test failed");
      $finish;
    end
  end

  // result side: mostly ready, short stalls now and then, rare long ones
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 7) == 0)
        pop_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                : $urandom_range(1, 4);
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one point beat; push stays high across back-to-back beats
  task automatic send_point(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z, input logic last, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push <= 1'b1;
    coord_x <= x; coord_y <= y; measured <= z; last_point <= last;
    do @(posedge clk_i); while (full);
  endtask

  task automatic go_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (fits_pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_min(input logic [MINP_W-1:0] v);
    go_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // shapes: 0 full range, 1 small range, 2 noisy plane, 3 constant x
  task automatic send_set(input int n, input int shape, input bit gaps);
    int          a, b, c;
    logic [15:0] x, y, z, xc;
    a  = $urandom_range(0, 400) - 200;
    b  = $urandom_range(0, 40) - 20;
    c  = $urandom_range(0, 40) - 20;
    xc = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      if (shape == 1 || shape == 2) begin
        x = 16'($urandom_range(0, 200) - 100);
        y = 16'($urandom_range(0, 200) - 100);
      end
      if (shape == 1) z = 16'($urandom_range(0, 2000) - 1000);
      if (shape == 2)
        z = 16'(a + b * $signed(x) + c * $signed(y) + $urandom_range(0, 6) - 3);
      if (shape == 3) x = xc;
      send_point(x, y, z, i == n - 1, gaps);
    end
  endtask

  initial begin
    int n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, min_points at reset value
    send_point(16'sd5, -16'sd7, 16'sd9, 1'b1, 1'b0);                  // too few
    send_point(16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 1'b0);
    send_point(16'h8000, 16'h7fff, 16'h0000, 1'b0, 1'b0);
    send_point(16'h7fff, 16'h8000, 16'hffff, 1'b0, 1'b0);
    send_point(16'h0001, 16'h8000, 16'h7fff, 1'b0, 1'b0);
    send_point(16'h8000, 16'h0000, 16'h8000, 1'b1, 1'b0);             // extreme fit
    send_set(8, 3, 1'b1);                                             // singular
    send_set(9, 2, 1'b1);

    write_min(11'd0);
    send_point(16'sd3, 16'sd4, 16'sd5, 1'b1, 1'b0);                   // one point
    send_set(2, 0, 1'b0);

    write_min(11'd2047);
    send_set(7, 1, 1'b1);

    write_min(11'd3);
    send_set(3, 0, 1'b1);

    // random sets, settings changed between phases
    n = 0;
    while (n < 860) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(3, 16);
      send_set(len, $urandom_range(0, 9) < 2 ? 3 : $urandom_range(0, 2), 1'b1);
      n += len;
      if ($urandom_range(0, 24) == 0) write_min(11'($urandom_range(3, 12)));
    end

    go_idle();
    if (error_count == 0 && fits_pending == 0) begin
      $display("least_squares_plane_fit_test passed");
    end else begin
      $display("least_squares_plane_fit_test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lspf_pkg.sv
hdl/lspf_fifo.sv
hdl/lspf_front.sv
hdl/lspf_solver.sv
hdl/least_squares_plane_fit.sv
tb/least_squares_plane_fit_checker.sv
tb/least_squares_plane_fit_test.sv
